// ===== src/tsdq_pkg.sv =====
// ----------------------------------------------------------------------------
// tsdq_pkg
// shared types, codes and helpers for the touch swipe direction queue
// ----------------------------------------------------------------------------
package tsdq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = PTR_W + 1;
    localparam int FILL_W      = 3;
    localparam int FILLX_W     = (CNT_W > FILL_W) ? CNT_W : FILL_W;

    localparam int COORD_W     = 16;
    localparam int MAG_W       = COORD_W + 1;
    localparam int ZONE_W      = 15;
    localparam int OP_W        = 3;
    localparam int ACT_W       = 3;
    localparam int IDX_W       = 3;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    typedef logic [PTR_W-1:0]          ptr_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [MAG_W-1:0]          mag_t;
    typedef logic [ZONE_W-1:0]         zone_t;
    typedef logic [OP_W-1:0]           op_t;
    typedef logic [ACT_W-1:0]          act_t;
    typedef logic [IDX_W-1:0]          idx_t;
    typedef logic [FILL_W-1:0]         fill_t;

    // opcodes
    localparam op_t OP_DOWN  = 3'd0;
    localparam op_t OP_MOVE  = 3'd1;
    localparam op_t OP_UP    = 3'd2;
    localparam op_t OP_POP   = 3'd3;
    localparam op_t OP_CLEAR = 3'd4;

    // actions
    localparam act_t ACT_NONE  = 3'd0;
    localparam act_t ACT_UP    = 3'd1;
    localparam act_t ACT_DOWN  = 3'd2;
    localparam act_t ACT_LEFT  = 3'd3;
    localparam act_t ACT_RIGHT = 3'd4;

    // configuration register indexes
    localparam idx_t REG_PAD_CENTER_X    = 3'd0;
    localparam idx_t REG_PAD_CENTER_Y    = 3'd1;
    localparam idx_t REG_PAD_HALF_SIZE   = 3'd2;
    localparam idx_t REG_DEAD_ZONE       = 3'd3;
    localparam idx_t REG_SWIPE_THRESHOLD = 3'd4;

    localparam zone_t DEAD_ZONE_RESET       = 15'd20;
    localparam zone_t SWIPE_THRESHOLD_RESET = 15'd30;

    // magnitude of a signed coordinate, -32768 gives 32768
    function automatic mag_t mag17(input coord_t v);
        mag_t ext;
        ext = {v[COORD_W-1], v};
        return v[COORD_W-1] ? mag_t'(-ext) : ext;
    endfunction

    // dominant-axis direction of an offset
    function automatic act_t dominant_dir(input coord_t dx, input coord_t dy);
        mag_t mx;
        mag_t my;
        mx = mag17(dx);
        my = mag17(dy);
        if (mx > my)
            return (!dx[COORD_W-1] && (dx != '0)) ? ACT_RIGHT : ACT_LEFT;
        return (!dy[COORD_W-1] && (dy != '0)) ? ACT_DOWN : ACT_UP;
    endfunction

    function automatic ptr_t ptr_next(input ptr_t p);
        return (p == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
    endfunction

endpackage

// ===== src/touch_swipe_direction_queue.sv =====
// ----------------------------------------------------------------------------
// touch_swipe_direction_queue
// four-direction touch gesture detector feeding a small action queue
// ----------------------------------------------------------------------------
// Each input transaction carries a touch down, move or up event, a pop or a
// clear, and gives exactly one output transaction with the popped action (zero
// unless a pop finds an entry) and the queue fill after the item. One item is
// accepted per clock unless the read stage is stalled: the gesture compare,
// pointer update and ring write all settle in the accept cycle, the ring read
// for a pop returns in the next cycle from the synchronous ram, and a
// two-register output path (read stage plus output register) keeps the input
// open while one result waits at the output. The queue holds at most seven
// directions; a push into a full queue drops the oldest entry. Configuration
// writes are always accepted and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module touch_swipe_direction_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream: opcode [2:0], pos_x [18:3], pos_y [34:19], zero fill [39:35]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tsdq_pkg::IN_TDATA_W-1:0]     s_tdata,
    // output stream: action [2:0], queue_fill [5:3], zero fill [7:6]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tsdq_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tsdq_pkg::IDX_W-1:0]          cfg_index,
    input  logic [tsdq_pkg::COORD_W-1:0]        cfg_data
);

    import tsdq_pkg::*;

    // configuration registers
    coord_t pad_cx_reg;
    coord_t pad_cy_reg;
    coord_t half_reg;
    zone_t  dead_reg;
    zone_t  thr_reg;

    // queue pointers and touch state
    ptr_t   rp_reg, rp_next;
    ptr_t   wp_reg, wp_next;
    logic   active_reg, active_next;
    logic   in_pad_reg, in_pad_next;
    coord_t start_x_reg, start_x_next;
    coord_t start_y_reg, start_y_next;

    // read stage (waits for ram data) and output register
    logic   p_valid_reg, p_valid_next;
    logic   p_hit_reg, p_hit_next;
    fill_t  p_fill_reg, p_fill_next;
    logic   m_valid_reg, m_valid_next;
    act_t   m_action_reg, m_action_next;
    fill_t  m_fill_reg, m_fill_next;

    // input field decode
    op_t    op;
    coord_t pos_x;
    coord_t pos_y;

    logic   in_acc;
    logic   out_free;
    logic   p_adv;

    // gesture datapath
    logic   enabled;
    coord_t ref_x;
    coord_t ref_y;
    coord_t dx;
    coord_t dy;
    mag_t   mag_x;
    mag_t   mag_y;
    mag_t   half_mag;
    logic   in_zone;
    logic   outside_dead;
    logic   over_thr;
    act_t   dir;

    // queue write / read
    logic   push;
    logic   pop_hit;
    act_t   ram_rdata;
    ptr_t   wp_inc;
    ptr_t   rp_after;
    logic [FILLX_W-1:0] fill_wide;

    assign op    = s_tdata[2:0];
    assign pos_x = s_tdata[18:3];
    assign pos_y = s_tdata[34:19];

    // the read stage only advances when the output register is free
    assign out_free = !m_valid_reg || m_tready;
    assign p_adv    = p_valid_reg && out_free;
    assign s_tready = !p_valid_reg || out_free;
    assign in_acc   = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_cx_reg <= '0;
            pad_cy_reg <= '0;
            half_reg   <= '0;
            dead_reg   <= DEAD_ZONE_RESET;
            thr_reg    <= SWIPE_THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PAD_CENTER_X:    pad_cx_reg <= cfg_data;
                REG_PAD_CENTER_Y:    pad_cy_reg <= cfg_data;
                REG_PAD_HALF_SIZE:   half_reg   <= cfg_data;
                REG_DEAD_ZONE:       dead_reg   <= cfg_data[ZONE_W-1:0];
                REG_SWIPE_THRESHOLD: thr_reg    <= cfg_data[ZONE_W-1:0];
                default:             ;
            endcase
        end
    end

    // gestures need a positive pad half size
    assign enabled  = !half_reg[COORD_W-1] && (half_reg != '0);
    assign half_mag = {1'b0, half_reg};

    // one shared subtractor pair: release compares against the touch-down
    // point, down and move against the pad centre
    assign ref_x = (op == OP_UP) ? start_x_reg : pad_cx_reg;
    assign ref_y = (op == OP_UP) ? start_y_reg : pad_cy_reg;
    assign dx    = coord_t'(pos_x - ref_x);
    assign dy    = coord_t'(pos_y - ref_y);
    assign mag_x = mag17(dx);
    assign mag_y = mag17(dy);

    assign in_zone      = enabled && (mag_x <= half_mag) && (mag_y <= half_mag);
    assign outside_dead = !((mag_x < {2'b00, dead_reg}) && (mag_y < {2'b00, dead_reg}));
    assign over_thr     = (mag_x > {2'b00, thr_reg}) || (mag_y > {2'b00, thr_reg});
    assign dir          = dominant_dir(dx, dy);

    assign wp_inc = ptr_next(wp_reg);

    // per-item state update
    always_comb
    begin
        active_next  = active_reg;
        in_pad_next  = in_pad_reg;
        start_x_next = start_x_reg;
        start_y_next = start_y_reg;
        push         = 1'b0;
        pop_hit      = 1'b0;
        rp_after     = rp_reg;
        rp_next      = rp_reg;
        wp_next      = wp_reg;

        if (in_acc)
        begin
            unique case (op)
                OP_DOWN:
                begin
                    start_x_next = pos_x;
                    start_y_next = pos_y;
                    active_next  = 1'b1;
                    in_pad_next  = in_zone;
                    push         = in_zone && outside_dead;
                end
                OP_MOVE:
                begin
                    push = active_reg && in_pad_reg && enabled && outside_dead;
                end
                OP_UP:
                begin
                    if (active_reg)
                    begin
                        active_next = 1'b0;
                        in_pad_next = 1'b0;
                        // flag as captured at touch-down decides swipe vs pad
                        push        = !in_pad_reg && enabled && over_thr;
                    end
                end
                OP_POP:
                begin
                    if (rp_reg != wp_reg)
                    begin
                        pop_hit  = 1'b1;
                        rp_after = ptr_next(rp_reg);
                    end
                end
                OP_CLEAR:
                begin
                    rp_after    = '0;
                    active_next = 1'b0;
                    in_pad_next = 1'b0;
                end
                default: ;
            endcase

            rp_next = rp_after;
            if (op == OP_CLEAR)
            begin
                wp_next = '0;
            end
            if (push)
            begin
                // full queue drops its oldest entry
                if (wp_inc == rp_reg)
                begin
                    rp_next = ptr_next(rp_reg);
                end
                wp_next = wp_inc;
            end
        end
    end

    // fill after this item, reported modulo eight
    always_comb
    begin
        if (wp_next >= rp_next)
        begin
            fill_wide = FILLX_W'(wp_next) - FILLX_W'(rp_next);
        end
        else
        begin
            fill_wide = FILLX_W'(wp_next) + FILLX_W'(QUEUE_DEPTH) - FILLX_W'(rp_next);
        end
    end

    // action ring: written on push, read at the read pointer on a pop
    tsdq_ram #(
        .WIDTH (ACT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (push),
        .waddr (wp_reg),
        .wdata (dir),
        .re    (pop_hit),
        .raddr (rp_reg),
        .rdata (ram_rdata)
    );

    // pipeline control
    always_comb
    begin
        p_valid_next  = p_valid_reg;
        p_hit_next    = p_hit_reg;
        p_fill_next   = p_fill_reg;
        m_valid_next  = m_valid_reg;
        m_action_next = m_action_reg;
        m_fill_next   = m_fill_reg;

        if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (p_adv)
        begin
            m_valid_next  = 1'b1;
            m_action_next = p_hit_reg ? ram_rdata : ACT_NONE;
            m_fill_next   = p_fill_reg;
            p_valid_next  = 1'b0;
        end
        if (in_acc)
        begin
            p_valid_next = 1'b1;
            p_hit_next   = pop_hit;
            p_fill_next  = fill_wide[FILL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg      <= '0;
            wp_reg      <= '0;
            active_reg  <= 1'b0;
            in_pad_reg  <= 1'b0;
            start_x_reg <= '0;
            start_y_reg <= '0;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            rp_reg      <= rp_next;
            wp_reg      <= wp_next;
            active_reg  <= active_next;
            in_pad_reg  <= in_pad_next;
            start_x_reg <= start_x_next;
            start_y_reg <= start_y_next;
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        p_hit_reg    <= p_hit_next;
        p_fill_reg   <= p_fill_next;
        m_action_reg <= m_action_next;
        m_fill_reg   <= m_fill_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_fill_reg, m_action_reg};

    // clear empties the queue and ends the touch
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && op == OP_CLEAR) |=> (rp_reg == '0 && wp_reg == '0 && !active_reg))
        else $error("clear did not reset queue and touch state");

    // a pop that finds an entry moves the read pointer
    a_pop_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && op == OP_POP && rp_reg != wp_reg) |=> (rp_reg != $past(rp_reg)))
        else $error("pop hit without read pointer advance");

    // a stalled read stage keeps its transaction
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (p_valid_reg && !out_free) |=> (p_valid_reg && $stable(p_fill_reg)
            && $stable(p_hit_reg)))
        else $error("read stage lost a transaction under stall");

    // the in-pad flag is only set while a touch is active
    a_pad_flag: assert property (@(posedge clk) disable iff (!rst_n)
        in_pad_reg |-> active_reg)
        else $error("in-pad flag set without active touch");

endmodule

// ===== src/tsdq_ram.sv =====
// ----------------------------------------------------------------------------
// tsdq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module tsdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
